/* rtl/wsd_pkg.sv */
`default_nettype none

package wsd_pkg;

    localparam int VAL_W       = 18;
    localparam int IDX_W       = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int MAP_N       = 5;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic signed [IDX_W-1:0] IDX_LO = -3'sd2;
    localparam logic signed [IDX_W-1:0] IDX_HI = 3'sd2;

    // the nine base polynomials of the spin-2 table
    typedef enum logic [3:0] {
        BASE_D00,
        BASE_D10,
        BASE_D11,
        BASE_D1M1,
        BASE_D22,
        BASE_D21,
        BASE_D20,
        BASE_D2M1,
        BASE_D2M2
    } t_base;

    typedef struct packed {
        t_base base;
        logic  neg;
    } t_entry;

    typedef struct packed {
        logic signed [VAL_W-1:0] cos_theta;
        t_base                   base;
        logic                    neg;
        logic                    bad;
    } t_item;

    // rows m = -2..2, columns n = -2..2
    // neg already folds in the leading minus of d10, d21 and d2m1
    localparam t_entry ELEM_MAP [MAP_N][MAP_N] = '{
        '{'{BASE_D22, 1'b0},  '{BASE_D21, 1'b0},  '{BASE_D20, 1'b0},
          '{BASE_D2M1, 1'b0}, '{BASE_D2M2, 1'b0}},
        '{'{BASE_D21, 1'b1},  '{BASE_D11, 1'b0},  '{BASE_D10, 1'b0},
          '{BASE_D1M1, 1'b0}, '{BASE_D2M1, 1'b0}},
        '{'{BASE_D20, 1'b0},  '{BASE_D10, 1'b1},  '{BASE_D00, 1'b0},
          '{BASE_D10, 1'b0},  '{BASE_D20, 1'b0}},
        '{'{BASE_D2M1, 1'b1}, '{BASE_D1M1, 1'b0}, '{BASE_D10, 1'b1},
          '{BASE_D11, 1'b0},  '{BASE_D21, 1'b0}},
        '{'{BASE_D2M2, 1'b0}, '{BASE_D2M1, 1'b1}, '{BASE_D20, 1'b0},
          '{BASE_D21, 1'b1},  '{BASE_D22, 1'b0}}
    };

endpackage

`default_nettype wire

/* rtl/wigner_small_d_j2.sv */
// pipeline: an item passes the queue, two operand stages, the FRAC_BITS + 1 stage root pipeline,
// two product and two rounding stages and the output register
// throughput: one item per cycle while the output is not stalled; a four-entry queue absorbs output stalls
// reset: i_rst_n synchronous, active low; clears the queue and all stage valid bits
`default_nettype none

module wigner_small_d_j2 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cos_theta[17:0], m_index[20:18], n_index[23:21]
    input  logic [wsd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // d_value[17:0], zeros above
    output logic [wsd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // bad_index[0]
    output logic [0:0]                         o_m_axis_tuser
);

    import wsd_pkg::*;

    logic                    w_q_full;
    logic                    w_q_empty;
    logic                    w_wr_en;
    logic                    w_rd_en;
    t_item                   w_wr_item;
    t_item                   w_rd_item;
    logic signed [VAL_W-1:0] w_d_value;
    logic                    w_bad;

    wsd_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tdata  (i_s_axis_tdata),
        .i_q_full   (w_q_full),
        .o_s_tready (o_s_axis_tready),
        .o_wr_en    (w_wr_en),
        .o_item     (w_wr_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_wr_en),
        .i_item  (w_wr_item),
        .i_rd_en (w_rd_en),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_rd_item)
    );

    wsd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_q_empty),
        .i_item     (w_rd_item),
        .o_rd_en    (w_rd_en),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_d_value  (w_d_value),
        .o_bad      (w_bad)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-VAL_W){1'b0}}, w_d_value};
    assign o_m_axis_tuser = w_bad;

endmodule

`default_nettype wire

/* rtl/wsd_front.sv */
`default_nettype none

module wsd_front (
    input  logic                             i_s_tvalid,
    input  logic [wsd_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_q_full,
    output logic                             o_s_tready,
    output logic                             o_wr_en,
    output wsd_pkg::t_item                   o_item
);

    import wsd_pkg::*;

    logic signed [IDX_W-1:0] w_m;
    logic signed [IDX_W-1:0] w_n;
    logic [IDX_W-1:0]        w_row;
    logic [IDX_W-1:0]        w_col;
    logic                    w_bad;
    t_entry                  w_ent;

    assign w_m = i_s_tdata[VAL_W +: IDX_W];
    assign w_n = i_s_tdata[VAL_W+IDX_W +: IDX_W];

    assign w_bad = (w_m < IDX_LO) || (w_m > IDX_HI) || (w_n < IDX_LO) || (w_n > IDX_HI);

    assign w_row = $unsigned(w_m) - $unsigned(IDX_LO);
    assign w_col = $unsigned(w_n) - $unsigned(IDX_LO);

    always_comb begin
        if (w_bad) begin
            w_ent = '{base: BASE_D00, neg: 1'b0};
        end else begin
            w_ent = ELEM_MAP[w_row][w_col];
        end
    end

    assign o_item = '{
        cos_theta: i_s_tdata[VAL_W-1:0],
        base:      w_ent.base,
        neg:       w_ent.neg,
        bad:       w_bad
    };

    assign o_s_tready = !i_q_full;
    assign o_wr_en    = i_s_tvalid && !i_q_full;

endmodule

`default_nettype wire

/* rtl/wsd_queue.sv */
`default_nettype none

module wsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  wsd_pkg::t_item i_item,
    input  logic           i_rd_en,
    output logic           o_full,
    output logic           o_empty,
    output wsd_pkg::t_item o_item
);

    import wsd_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_wr_en);
        n_rd_ptr = r_rd_ptr + QPTR_W'(i_rd_en);
        n_count  = r_count + QCNT_W'(i_wr_en) - QCNT_W'(i_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* rtl/wsd_back.sv */
`default_nettype none

module wsd_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  wsd_pkg::t_item                 i_item,
    output logic                           o_rd_en,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic signed [wsd_pkg::VAL_W-1:0] o_d_value,
    output logic                           o_bad
);

    import wsd_pkg::*;

    function automatic longint unsigned f_isqrt(input longint unsigned x);
        longint unsigned y;
        longint unsigned r;
        longint unsigned b;
        y = x;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (y >= r + b) begin
                y = y - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam int F   = FRAC_BITS;
    localparam int K   = F + 1;                           // root bits
    localparam int XW  = 2 * K;                           // padded radicand
    localparam int RMW = K + 2;                           // root remainder
    localparam int AW  = ((F > VAL_W) ? F : VAL_W) + 2;   // first multiplier operands
    localparam int PW  = 2 * AW;
    localparam int CW  = 2 * VAL_W;
    localparam int DW  = ((2 * F > CW - 1) ? 2 * F : CW - 1) + 2;
    localparam int TW  = F + 2;                           // second multiplier, left operand
    localparam int BW2 = (TW > VAL_W) ? TW : VAL_W;
    localparam int QW  = TW + BW2;
    localparam int NST = K + 7;

    localparam longint unsigned K1_U = f_isqrt(64'd3 << (2 * F - 1));
    localparam longint unsigned K2_U = f_isqrt(64'd3 << (2 * F - 3));

    localparam logic signed [AW-1:0]  K1_A     = AW'(K1_U);
    localparam logic signed [BW2-1:0] K2_B     = BW2'(K2_U);
    localparam logic signed [AW-1:0]  ONE_A    = {{(AW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [DW-1:0]  ONE_SQ_D = {{(DW-1){1'b0}}, 1'b1} << (2 * F);
    localparam logic signed [PW-1:0]  ONE_SQ_P = {{(PW-1){1'b0}}, 1'b1} << (2 * F);
    localparam logic signed [PW-1:0]  RND_F0   = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [PW-1:0]  RND_F1   = {{(PW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [PW-1:0]  RND_F2   = {{(PW-1){1'b0}}, 1'b1} << (F + 1);
    localparam logic signed [PW-1:0]  BIAS_D00 = RND_F1 - ONE_SQ_P;
    localparam logic signed [QW-1:0]  RND_Q    = {{(QW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [PW-1:0]  SAT_HI   = PW'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [PW-1:0]  SAT_LO   = PW'(-(2 ** (VAL_W - 1)));

    typedef struct packed {
        logic signed [AW-1:0]    a;
        logic signed [AW-1:0]    b;
        t_base                   base;
        logic                    neg;
        logic                    bad;
        logic signed [VAL_W-1:0] c;
    } t_job;

    logic             w_en;
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   n_vld;

    // stall the whole pipe only while the result waits at the output
    assign w_en    = !r_vld[NST-1] || i_m_tready;
    assign o_rd_en = w_en && !i_empty;
    assign n_vld   = {r_vld[NST-2:0], !i_empty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // c*c and the operands that do not need the sine
    logic signed [AW-1:0] w_c;
    logic signed [AW-1:0] w_u;
    logic signed [AW-1:0] w_v;
    logic signed [AW-1:0] w_tcm;
    logic signed [AW-1:0] w_tcp;
    logic signed [AW-1:0] w_3c;
    logic signed [CW-1:0] w_cc;
    t_job                 w_job0;
    t_job                 r_b0_job;
    logic [CW-1:0]        r_b0_cc;

    assign w_c   = {{(AW-VAL_W){i_item.cos_theta[VAL_W-1]}}, i_item.cos_theta};
    assign w_u   = ONE_A + w_c;
    assign w_v   = ONE_A - w_c;
    assign w_tcm = (w_c <<< 1) - ONE_A;
    assign w_tcp = (w_c <<< 1) + ONE_A;
    assign w_3c  = w_c + (w_c <<< 1);
    assign w_cc  = i_item.cos_theta * i_item.cos_theta;

    always_comb begin
        w_job0.base = i_item.base;
        w_job0.neg  = i_item.neg;
        w_job0.bad  = i_item.bad;
        w_job0.c    = i_item.cos_theta;
        unique case (i_item.base)
            BASE_D00: begin
                w_job0.a = w_3c;
                w_job0.b = w_c;
            end
            BASE_D10: begin
                w_job0.a = K1_A;
                w_job0.b = '0;
            end
            BASE_D11: begin
                w_job0.a = w_u;
                w_job0.b = w_tcm;
            end
            BASE_D1M1: begin
                w_job0.a = w_v;
                w_job0.b = w_tcp;
            end
            BASE_D22: begin
                w_job0.a = w_u;
                w_job0.b = w_u;
            end
            BASE_D21: begin
                w_job0.a = w_u;
                w_job0.b = '0;
            end
            BASE_D2M1: begin
                w_job0.a = w_v;
                w_job0.b = '0;
            end
            BASE_D2M2: begin
                w_job0.a = w_v;
                w_job0.b = w_v;
            end
            default: begin
                w_job0.a = '0;
                w_job0.b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b0_job <= w_job0;
            r_b0_cc  <= w_cc;
        end
    end

    // radicand one^2 - c^2, clamped at zero
    logic signed [DW-1:0] w_diff;
    logic [XW-1:0]        w_rad;
    t_job                 r_b1_job;
    logic [XW-1:0]        r_b1_x;

    assign w_diff = ONE_SQ_D - $signed({{(DW-CW){1'b0}}, r_b0_cc});
    assign w_rad  = w_diff[DW-1] ? '0 : w_diff[XW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_job <= r_b0_job;
            r_b1_x   <= w_rad;
        end
    end

    // square root, one result bit per stage
    t_job           r_sq_job  [K];
    logic [K-1:0]   r_sq_root [K];
    logic [RMW-1:0] r_sq_rem  [K-1];
    logic [XW-1:0]  r_sq_x    [K-1];

    for (genvar j = 0; j < K; j++) begin : g_sq
        logic [RMW-1:0] w_rem_prev;
        logic [K-1:0]   w_root_prev;
        logic [XW-1:0]  w_x_prev;
        t_job           w_job_prev;
        logic [RMW-1:0] w_rem_in;
        logic [RMW-1:0] w_trial;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_rem_prev  = '0;
            assign w_root_prev = '0;
            assign w_x_prev    = r_b1_x;
            assign w_job_prev  = r_b1_job;
        end else begin : g_next
            assign w_rem_prev  = r_sq_rem[j-1];
            assign w_root_prev = r_sq_root[j-1];
            assign w_x_prev    = r_sq_x[j-1];
            assign w_job_prev  = r_sq_job[j-1];
        end

        assign w_rem_in = {w_rem_prev[RMW-3:0], w_x_prev[XW-1 -: 2]};
        assign w_trial  = {w_root_prev, 2'b01};
        assign w_ge     = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_job[j]  <= w_job_prev;
                r_sq_root[j] <= {w_root_prev[K-2:0], w_ge};
            end
        end

        if (j < K - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_rem[j] <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
                    r_sq_x[j]   <= w_x_prev << 2;
                end
            end
        end
    end

    // first product
    logic signed [AW-1:0] w_s;
    logic signed [AW-1:0] w_op_a;
    logic signed [AW-1:0] w_op_b;
    t_job                 w_jm;
    t_job                 r_m1_job;
    logic signed [PW-1:0] r_m1_prod;

    assign w_jm   = r_sq_job[K-1];
    assign w_s    = {{(AW-K){1'b0}}, r_sq_root[K-1]};
    assign w_op_a = (w_jm.base == BASE_D20) ? w_s : w_jm.a;
    assign w_op_b = (w_jm.base == BASE_D10 || w_jm.base == BASE_D21 ||
                     w_jm.base == BASE_D20 || w_jm.base == BASE_D2M1) ? w_s : w_jm.b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_job  <= w_jm;
            r_m1_prod <= w_op_a * w_op_b;
        end
    end

    // round to nearest, ties up: add half and shift arithmetically (for d00 the bias also subtracts one squared)
    logic signed [PW-1:0] w_sum1;
    logic signed [PW-1:0] w_r1;
    t_job                 r_r1_job;
    logic signed [PW-1:0] r_r1_val;

    always_comb begin
        unique case (r_m1_job.base)
            BASE_D22, BASE_D2M2: begin
                w_sum1 = r_m1_prod + RND_F2;
                w_r1   = w_sum1 >>> (F + 2);
            end
            BASE_D10, BASE_D20: begin
                w_sum1 = r_m1_prod + RND_F0;
                w_r1   = w_sum1 >>> F;
            end
            BASE_D00: begin
                w_sum1 = r_m1_prod + BIAS_D00;
                w_r1   = w_sum1 >>> (F + 1);
            end
            default: begin
                w_sum1 = r_m1_prod + RND_F1;
                w_r1   = w_sum1 >>> (F + 1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_job <= r_m1_job;
            r_r1_val <= w_r1;
        end
    end

    // second product for d10 (times c) and d20 (times sqrt(6)/4)
    logic signed [TW-1:0]  w_t;
    logic signed [BW2-1:0] w_op_b2;
    t_job                  r_m2_job;
    logic signed [PW-1:0]  r_m2_val;
    logic signed [QW-1:0]  r_m2_prod;

    assign w_t     = r_r1_val[TW-1:0];
    assign w_op_b2 = (r_r1_job.base == BASE_D10) ? BW2'(r_r1_job.c) : K2_B;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_job  <= r_r1_job;
            r_m2_val  <= r_r1_val;
            r_m2_prod <= w_t * w_op_b2;
        end
    end

    logic signed [QW-1:0] w_sum2;
    logic signed [PW-1:0] w_r2;
    t_job                 r_r2_job;
    logic signed [PW-1:0] r_r2_val;

    assign w_sum2 = r_m2_prod + RND_Q;
    assign w_r2   = (r_m2_job.base == BASE_D10 || r_m2_job.base == BASE_D20) ?
                    PW'(w_sum2 >>> F) : r_m2_val;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2_job <= r_m2_job;
            r_r2_val <= w_r2;
        end
    end

    // sign, saturation and the bad-index override
    logic signed [PW-1:0]    w_sv;
    logic signed [VAL_W-1:0] w_d;
    logic signed [VAL_W-1:0] r_o_d;
    logic                    r_o_bad;

    assign w_sv = r_r2_job.neg ? -r_r2_val : r_r2_val;

    always_comb begin
        priority if (r_r2_job.bad) begin
            w_d = '0;
        end else if (w_sv > SAT_HI) begin
            w_d = SAT_HI[VAL_W-1:0];
        end else if (w_sv < SAT_LO) begin
            w_d = SAT_LO[VAL_W-1:0];
        end else begin
            w_d = w_sv[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_d   <= w_d;
            r_o_bad <= r_r2_job.bad;
        end
    end

    assign o_m_tvalid = r_vld[NST-1];
    assign o_d_value  = r_o_d;
    assign o_bad      = r_o_bad;

endmodule

`default_nettype wire

/* rtl/wsd_chk.sv */
`default_nettype none

module wsd_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [wsd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [wsd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                      o_m_axis_tuser
);

    import wsd_pkg::*;

    localparam int DEPTH = QDEPTH + FRAC_BITS + 8;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic            w_in_acc;
    logic            w_out_acc;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign n_count   = r_count + CNTW'(w_in_acc) - CNTW'(w_out_acc);

    // items in flight between the two sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_count != '0))
        else $error("result delivered with no item in flight");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("bad index result carries a nonzero value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("output item changed while stalled");

endmodule

bind wigner_small_d_j2 wsd_chk #(.FRAC_BITS(FRAC_BITS)) u_wsd_chk (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import wsd_pkg::*;

    localparam int F          = 16;
    localparam int N_RANDOM   = 1500;
    localparam int CALM_TAIL  = 300;
    localparam int DRAIN_WAIT = 40;

    localparam longint VAL_MAX = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    // which base polynomial and whether to negate it, rows m = -2..2, columns n = -2..2
    typedef struct packed {
        t_base b;
        logic  flip;
    } t_pick;

    localparam t_pick PICK [5][5] = '{
        '{'{BASE_D22, 1'b0},  '{BASE_D21, 1'b1},  '{BASE_D20, 1'b0},
          '{BASE_D2M1, 1'b1}, '{BASE_D2M2, 1'b0}},
        '{'{BASE_D21, 1'b0},  '{BASE_D11, 1'b0},  '{BASE_D10, 1'b1},
          '{BASE_D1M1, 1'b0}, '{BASE_D2M1, 1'b1}},
        '{'{BASE_D20, 1'b0},  '{BASE_D10, 1'b0},  '{BASE_D00, 1'b0},
          '{BASE_D10, 1'b1},  '{BASE_D20, 1'b0}},
        '{'{BASE_D2M1, 1'b0}, '{BASE_D1M1, 1'b0}, '{BASE_D10, 1'b0},
          '{BASE_D11, 1'b0},  '{BASE_D21, 1'b1}},
        '{'{BASE_D2M2, 1'b0}, '{BASE_D2M1, 1'b0}, '{BASE_D20, 1'b0},
          '{BASE_D21, 1'b0},  '{BASE_D22, 1'b0}}
    };

    typedef struct {
        logic [VAL_W-1:0] d;
        logic             bad;
    } t_elem;

    // divide by 2^k, round to nearest with ties up
    function automatic longint round_shift(longint v, int k);
        longint t;
        t = v + (longint'(1) << (k - 1));
        return t >>> k;
    endfunction

    function automatic longint floor_root(longint x);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_elem predict_elem(logic [IN_TDATA_W-1:0] tdata);
        longint c, one, rad, s, k1, k2, d;
        longint bv [9];
        int     m, n;
        t_pick  p;
        t_elem  e;
        c   = longint'($signed(tdata[VAL_W-1:0]));
        m   = int'($signed(tdata[VAL_W+IDX_W-1:VAL_W]));
        n   = int'($signed(tdata[VAL_W+2*IDX_W-1:VAL_W+IDX_W]));
        one = longint'(1) << F;
        rad = one * one - c * c;
        if (rad < 0)
            rad = 0;
        s  = floor_root(rad);
        k1 = floor_root(longint'(3) << (2 * F - 1));
        k2 = floor_root(longint'(3) << (2 * F - 3));
        bv[BASE_D00]  = round_shift(3 * c * c - one * one, F + 1);
        bv[BASE_D10]  = -round_shift(round_shift(k1 * s, F) * c, F);
        bv[BASE_D11]  = round_shift((one + c) * (2 * c - one), F + 1);
        bv[BASE_D1M1] = round_shift((one - c) * (2 * c + one), F + 1);
        bv[BASE_D22]  = round_shift((one + c) * (one + c), F + 2);
        bv[BASE_D21]  = -round_shift((one + c) * s, F + 1);
        bv[BASE_D20]  = round_shift(k2 * round_shift(s * s, F), F);
        bv[BASE_D2M1] = -round_shift((one - c) * s, F + 1);
        bv[BASE_D2M2] = round_shift((one - c) * (one - c), F + 2);
        if (m < -2 || m > 2 || n < -2 || n > 2) begin
            e.d   = '0;
            e.bad = 1'b1;
        end else begin
            p = PICK[m + 2][n + 2];
            d = p.flip ? -bv[p.b] : bv[p.b];
            if (d > VAL_MAX)
                d = VAL_MAX;
            if (d < VAL_MIN)
                d = VAL_MIN;
            e.d   = d[VAL_W-1:0];
            e.bad = 1'b0;
        end
        return e;
    endfunction

    class d2_board;
        t_elem pending_elems[$];
        int    mismatches;
        int    items_in;
        int    results_seen;
        int    bad_seen;

        function void note_input(logic [IN_TDATA_W-1:0] tdata);
            pending_elems.push_back(predict_elem(tdata));
            items_in++;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            t_elem want;
            results_seen++;
            if (tuser)
                bad_seen++;
            if (pending_elems.size() == 0) begin
                $display("%0t: result with nothing expected, d_value %0d bad_index %0b",
                         $time, $signed(tdata[VAL_W-1:0]), tuser);
                mismatches++;
                return;
            end
            want = pending_elems.pop_front();
            if (tdata !== {{(OUT_TDATA_W-VAL_W){1'b0}}, want.d}) begin
                $display("%0t: d_value mismatch, expected %0d (tdata %h) got %0d (tdata %h)",
                         $time, $signed(want.d), {{(OUT_TDATA_W-VAL_W){1'b0}}, want.d},
                         $signed(tdata[VAL_W-1:0]), tdata);
                mismatches++;
            end
            if (tuser !== want.bad) begin
                $display("%0t: bad_index mismatch, expected %0b got %0b",
                         $time, want.bad, tuser);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // cos_theta[17:0], m_index[20:18], n_index[23:21]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // d_value[17:0], zeros above
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // bad_index[0]
    logic [0:0]             o_m_axis_tuser;

    d2_board board = new();
    bit      out_stall_on;
    int      in_idle_rate;

    wigner_small_d_j2 #(
        .FRAC_BITS(F)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_input(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
        end
    end

    // output side: random stall bursts while enabled
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (out_stall_on && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(int cos_val, int m, int n);
        logic [VAL_W-1:0] c;
        logic [IDX_W-1:0] mi, ni;
        c  = cos_val[VAL_W-1:0];
        mi = m[IDX_W-1:0];
        ni = n[IDX_W-1:0];
        if (in_idle_rate > 0 && $urandom_range(0, 99) < in_idle_rate) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tdata  = {ni, mi, c};
        i_s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        i_s_axis_tvalid = 1'b0;
        while (board.pending_elems.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int cos_list [13];
        int k, r, c, m, n;
        cos_list = '{0, 65536, -65536, 131071, -131072, 32768, -32768,
                     1, -1, 65537, 46341, -46341, 65535};
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        out_stall_on    = 1'b0;
        in_idle_rate    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every (m, n) pair at a spread of cosines, then the out-of-range indices
        k = 0;
        for (m = -2; m <= 2; m++) begin
            for (n = -2; n <= 2; n++) begin
                send_item(cos_list[k % 13], m, n);
                k++;
            end
        end
        send_item(32768, 3, 0);
        send_item(-20000, 0, -4);
        send_item(131071, -3, 2);
        drain_all();

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 150 == 0) begin
                in_idle_rate = (k < N_RANDOM - CALM_TAIL && $urandom_range(0, 2) != 0) ? 25 : 0;
                out_stall_on = (k < N_RANDOM - CALM_TAIL) && ($urandom_range(0, 2) != 0);
            end
            if (k == 700)
                drain_all();
            r = $urandom_range(0, 99);
            m = $urandom_range(0, 4) - 2;
            n = $urandom_range(0, 4) - 2;
            if (r < 75) begin
                c = $urandom_range(0, 131072) - 65536;
            end else if (r < 85) begin
                c = $urandom_range(0, 262143);
            end else if (r < 92) begin
                c = ($urandom_range(0, 1) ? 65536 : -65536) + $urandom_range(0, 8) - 4;
            end else begin
                c = $urandom_range(0, 262143);
                m = $urandom_range(0, 7);
                n = $urandom_range(0, 7);
            end
            send_item(c, m, n);
        end
        out_stall_on = 1'b0;
        drain_all();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (board.pending_elems.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending_elems.size());
            board.mismatches++;
        end
        $display("checked %0d items against %0d results, %0d of them flagged as bad index",
                 board.items_in, board.results_seen, board.bad_seen);
        $display("all 25 index pairs, cosines past +/-1.0, and input/output stall bursts");
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* wigner_small_d_j2.f */
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_queue.sv
rtl/wsd_back.sv
rtl/wigner_small_d_j2.sv
rtl/wsd_chk.sv
tb/tb_top.sv
